[rtl/cascaded_pid_twin_thruster_defines.svh]
// Assertion helpers for the thruster controller. Each check is clocked on
// i_clk and is held off while i_rst_n is low.
`ifndef CASCADED_PID_TWIN_THRUSTER_DEFINES_SVH
`define CASCADED_PID_TWIN_THRUSTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CPT_ASSERT_SAME(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define CPT_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("next-cycle check failed");

`endif

[rtl/cpt_pkg.sv]
package cpt_pkg;

    localparam int STAGE_COUNT = 4;
    localparam int STAGE_W     = 2;
    localparam int DATA_W      = 32;
    localparam int ACT_W       = 24;
    localparam int DERIV_W     = 41;
    localparam int INTEG_W     = 48;
    localparam int INC_W       = 34;
    localparam int MA_W        = 34;
    localparam int MB_W        = 26;
    localparam int PROD_W      = MA_W + MB_W;
    localparam int ACC_W       = PROD_W;
    localparam int PART_W      = 25;
    localparam int FRAC_W      = 16;
    localparam int GAIN_W      = 18;
    localparam int CFG_W       = 24;
    localparam int CFG_IDX_W   = 3;
    localparam int PC_W        = 5;

    // Stage indexes.
    localparam logic [STAGE_W-1:0] STG_X = 2'd0;
    localparam logic [STAGE_W-1:0] STG_A = 2'd1;
    localparam logic [STAGE_W-1:0] STG_Y = 2'd2;
    localparam logic [STAGE_W-1:0] STG_S = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_THRUST_MEAN       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COMMON_GAIN       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIFFERENTIAL_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_TIME_STEP = 3'd4;

    typedef struct packed {
        logic signed [DATA_W-1:0] horizontal_error;
        logic signed [DATA_W-1:0] vertical_error;
        logic signed [DATA_W-1:0] vertical_speed;
        logic signed [DATA_W-1:0] tilt_angle;
    } t_in_word;

    typedef struct packed {
        logic signed [DATA_W-1:0] left_thrust;
        logic signed [DATA_W-1:0] right_thrust;
    } t_out_word;

    typedef struct packed {
        logic [16:0] thrust_mean;
        logic [16:0] common_gain;
        logic [16:0] differential_gain;
        logic [16:0] time_step;
        logic [23:0] inverse_time_step;
    } t_cfg;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } t_seq_state;

    typedef enum logic [2:0] {
        MA_HOLD,
        MA_DIFF,
        MA_ERR,
        MA_DLO,
        MA_DHI,
        MA_COMMON_ACT,
        MA_DIFF_ACT
    } t_ma_sel;

    typedef enum logic [2:0] {
        MB_HOLD,
        MB_INV,
        MB_DT,
        MB_KP,
        MB_KD,
        MB_CGAIN,
        MB_DGAIN
    } t_mb_sel;

    typedef enum logic [3:0] {
        POST_NONE,
        POST_DERIV,
        POST_INTEG,
        POST_ACC_LOAD,
        POST_ACC_ADD,
        POST_ACC_ADD_HI,
        POST_STAGE_OUT,
        POST_CPART,
        POST_DPART,
        POST_EMIT
    } t_post;

    typedef enum logic [1:0] {
        JUMP_NEXT,
        JUMP_STAGE,
        JUMP_END_WAIT
    } t_jump;

    typedef struct packed {
        logic             load_e;
        t_ma_sel          ma_sel;
        t_mb_sel          mb_sel;
        logic             mul_en;
        logic             prev_wr;
        t_post            post;
        t_jump            jump;
        logic [PC_W-1:0]  target;
    } t_ctrl;

    localparam t_ctrl CTRL_NOP = '{
        load_e:  1'b0,
        ma_sel:  MA_HOLD,
        mb_sel:  MB_HOLD,
        mul_en:  1'b0,
        prev_wr: 1'b0,
        post:    POST_NONE,
        jump:    JUMP_NEXT,
        target:  '0
    };

    localparam logic [PC_W-1:0] PC_LOOP_TOP = '0;

    function automatic logic [GAIN_W-1:0] p_gain(input logic [STAGE_W-1:0] stage);
        logic [GAIN_W-1:0] g;
        unique case (stage)
            STG_X: g = 18'd13107;
            STG_A: g = 18'd1311;
            STG_Y: g = 18'd163840;
            STG_S: g = 18'd65536;
        endcase
        return g;
    endfunction

    function automatic logic [GAIN_W-1:0] d_gain(input logic [STAGE_W-1:0] stage);
        logic [GAIN_W-1:0] g;
        unique case (stage)
            STG_X: g = 18'd13107;
            STG_A: g = 18'd655;
            STG_Y: g = 18'd98304;
            STG_S: g = 18'd0;
        endcase
        return g;
    endfunction

    function automatic logic signed [ACT_W-1:0] out_limit(input logic [STAGE_W-1:0] stage);
        logic signed [ACT_W-1:0] lim;
        unique case (stage)
            STG_X: lim = 24'sd1638400;
            STG_A: lim = 24'sd65536;
            STG_Y: lim = 24'sd6553600;
            STG_S: lim = 24'sd65536;
        endcase
        return lim;
    endfunction

    // Microprogram. Steps 0 to 12 run one PID stage and loop over the four
    // stages; steps 13 to 18 scale the two actions and hand out the word.
    function automatic t_ctrl ucode(input logic [PC_W-1:0] pc);
        t_ctrl w;
        w = CTRL_NOP;
        unique case (pc)
            PC_W'(0): w.load_e = 1'b1;
            PC_W'(1): begin
                w.ma_sel  = MA_DIFF;
                w.mb_sel  = MB_INV;
                w.prev_wr = 1'b1;
            end
            PC_W'(2): w.mul_en = 1'b1;
            PC_W'(3): begin
                w.post   = POST_DERIV;
                w.ma_sel = MA_ERR;
                w.mb_sel = MB_DT;
            end
            PC_W'(4): w.mul_en = 1'b1;
            PC_W'(5): begin
                w.post   = POST_INTEG;
                w.mb_sel = MB_KP;
            end
            PC_W'(6): w.mul_en = 1'b1;
            PC_W'(7): begin
                w.post   = POST_ACC_LOAD;
                w.ma_sel = MA_DLO;
                w.mb_sel = MB_KD;
            end
            PC_W'(8): w.mul_en = 1'b1;
            PC_W'(9): begin
                w.post   = POST_ACC_ADD;
                w.ma_sel = MA_DHI;
            end
            PC_W'(10): w.mul_en = 1'b1;
            PC_W'(11): w.post = POST_ACC_ADD_HI;
            PC_W'(12): begin
                w.post   = POST_STAGE_OUT;
                w.jump   = JUMP_STAGE;
                w.target = PC_LOOP_TOP;
            end
            PC_W'(13): begin
                w.ma_sel = MA_COMMON_ACT;
                w.mb_sel = MB_CGAIN;
            end
            PC_W'(14): w.mul_en = 1'b1;
            PC_W'(15): begin
                w.post   = POST_CPART;
                w.ma_sel = MA_DIFF_ACT;
                w.mb_sel = MB_DGAIN;
            end
            PC_W'(16): w.mul_en = 1'b1;
            PC_W'(17): w.post = POST_DPART;
            PC_W'(18): begin
                w.post = POST_EMIT;
                w.jump = JUMP_END_WAIT;
            end
            default: w = CTRL_NOP;
        endcase
        return w;
    endfunction

endpackage

[rtl/cpt_useq.sv]
`include "cascaded_pid_twin_thruster_defines.svh"

module cpt_useq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_out_free,
    output cpt_pkg::t_ctrl                o_ctrl,
    output logic [cpt_pkg::STAGE_W-1:0]   o_stage,
    output logic                          o_busy
);
    import cpt_pkg::*;

    t_seq_state         r_state, n_state;
    logic [PC_W-1:0]    r_pc, n_pc;
    logic [STAGE_W-1:0] r_stage, n_stage;
    t_ctrl              rom_word;

    localparam logic [STAGE_W-1:0] LAST_STAGE = STAGE_W'(STAGE_COUNT - 1);

    assign rom_word = ucode(r_pc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SEQ_IDLE;
            r_pc    <= '0;
            r_stage <= '0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_stage <= n_stage;
        end
    end

    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        n_stage = r_stage;
        o_ctrl  = CTRL_NOP;
        unique case (r_state)
            SEQ_IDLE: begin
                if (i_start) begin
                    n_state = SEQ_RUN;
                end
            end
            SEQ_RUN: begin
                o_ctrl = rom_word;
                unique case (rom_word.jump)
                    JUMP_NEXT: n_pc = r_pc + 1'b1;
                    JUMP_STAGE: begin
                        if (r_stage != LAST_STAGE) begin
                            n_stage = r_stage + 1'b1;
                            n_pc    = rom_word.target;
                        end else begin
                            n_pc = r_pc + 1'b1;
                        end
                    end
                    JUMP_END_WAIT: begin
                        // The last step stays put until the output register frees up.
                        if (i_out_free) begin
                            n_state = SEQ_IDLE;
                            n_pc    = '0;
                            n_stage = '0;
                        end
                    end
                    default: n_pc = r_pc + 1'b1;
                endcase
            end
        endcase
    end

    assign o_stage = r_stage;
    assign o_busy  = (r_state == SEQ_RUN);

    `CPT_ASSERT_SAME(a_idle_at_start, r_state == SEQ_IDLE, r_pc == '0 && r_stage == '0)
    `CPT_ASSERT_NEXT(a_start_runs, r_state == SEQ_IDLE && i_start, r_state == SEQ_RUN)
    `CPT_ASSERT_NEXT(a_wait_holds, r_state == SEQ_RUN && rom_word.jump == JUMP_END_WAIT && !i_out_free, r_state == SEQ_RUN && $stable(r_pc))

endmodule

[rtl/cpt_dpath.sv]
module cpt_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cpt_pkg::t_ctrl                i_ctrl,
    input  logic [cpt_pkg::STAGE_W-1:0]   i_stage,
    input  cpt_pkg::t_in_word             i_in_word,
    input  cpt_pkg::t_cfg                 i_cfg,
    output cpt_pkg::t_out_word            o_result
);
    import cpt_pkg::*;

    localparam int EW   = DATA_W + 1;
    localparam int QW   = ACC_W - FRAC_W;
    localparam int IS_W = INTEG_W + 1;
    localparam int SUM_W = DATA_W + 2;

    localparam logic signed [DATA_W-1:0] MAX32 = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] MIN32 = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [INTEG_W-1:0] MAX48 = {1'b0, {(INTEG_W-1){1'b1}}};
    localparam logic signed [INTEG_W-1:0] MIN48 = {1'b1, {(INTEG_W-1){1'b0}}};

    logic signed [DATA_W-1:0]  r_e;
    logic signed [DATA_W-1:0]  r_prev  [STAGE_COUNT];
    logic signed [INTEG_W-1:0] r_integ [STAGE_COUNT];
    logic signed [ACT_W-1:0]   r_y     [STAGE_COUNT];
    logic signed [MA_W-1:0]    r_ma;
    logic signed [MB_W-1:0]    r_mb;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [DERIV_W-1:0] r_deriv;
    logic signed [PART_W-1:0]  r_cpart;
    logic signed [PART_W-1:0]  r_dpart;

    logic signed [EW-1:0]      src_a, src_b, e_raw, diff;
    logic signed [DATA_W-1:0]  e_sat;
    logic signed [PROD_W-1:0]  mul_prod;
    logic signed [INC_W-1:0]   integ_inc;
    logic signed [IS_W-1:0]    integ_sum;
    logic signed [INTEG_W-1:0] integ_sat;
    logic signed [QW-1:0]      acc_q, lim_q;
    logic signed [ACT_W-1:0]   lim, stage_y;
    logic signed [SUM_W-1:0]   sum_l, sum_r;

    // Stage error: an input, its negation or a difference, saturated to 32 bits.
    always_comb begin
        unique case (i_stage)
            STG_X: begin
                src_a = '0;
                src_b = EW'(i_in_word.horizontal_error);
            end
            STG_A: begin
                src_a = EW'(i_in_word.tilt_angle);
                src_b = EW'(r_y[STG_X]);
            end
            STG_Y: begin
                src_a = EW'(i_in_word.vertical_error);
                src_b = '0;
            end
            STG_S: begin
                src_a = EW'(i_in_word.vertical_speed);
                src_b = EW'(r_y[STG_Y]);
            end
        endcase
        e_raw = src_a - src_b;
        if (e_raw[EW-1] != e_raw[EW-2]) begin
            e_sat = e_raw[EW-1] ? MIN32 : MAX32;
        end else begin
            e_sat = e_raw[DATA_W-1:0];
        end
    end

    assign diff     = EW'(r_e) - EW'(r_prev[i_stage]);
    assign mul_prod = r_ma * r_mb;

    always_comb begin
        integ_inc = r_prod[INC_W+FRAC_W-1:FRAC_W];
        integ_sum = IS_W'(r_integ[i_stage]) + IS_W'(integ_inc);
        if (integ_sum[IS_W-1] != integ_sum[IS_W-2]) begin
            integ_sat = integ_sum[IS_W-1] ? MIN48 : MAX48;
        end else begin
            integ_sat = integ_sum[INTEG_W-1:0];
        end
    end

    always_comb begin
        acc_q = r_acc[ACC_W-1:FRAC_W];
        lim   = out_limit(i_stage);
        lim_q = QW'(lim);
        if (acc_q > lim_q) begin
            stage_y = lim;
        end else if (acc_q < -lim_q) begin
            stage_y = -lim;
        end else begin
            stage_y = acc_q[ACT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < STAGE_COUNT; k++) begin
                r_prev[k]  <= '0;
                r_integ[k] <= '0;
            end
        end else begin
            if (i_ctrl.prev_wr) begin
                r_prev[i_stage] <= r_e;
            end
            if (i_ctrl.post == POST_INTEG) begin
                r_integ[i_stage] <= integ_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_e) begin
            r_e <= e_sat;
        end

        unique case (i_ctrl.ma_sel)
            MA_HOLD:       r_ma <= r_ma;
            MA_DIFF:       r_ma <= MA_W'(diff);
            MA_ERR:        r_ma <= MA_W'(r_e);
            MA_DLO:        r_ma <= MA_W'({1'b0, r_deriv[FRAC_W-1:0]});
            MA_DHI:        r_ma <= MA_W'($signed(r_deriv[DERIV_W-1:FRAC_W]));
            MA_COMMON_ACT: r_ma <= MA_W'(r_y[STG_S]);
            MA_DIFF_ACT:   r_ma <= MA_W'(r_y[STG_A]);
            default:       r_ma <= r_ma;
        endcase

        unique case (i_ctrl.mb_sel)
            MB_HOLD:  r_mb <= r_mb;
            MB_INV:   r_mb <= MB_W'({1'b0, i_cfg.inverse_time_step});
            MB_DT:    r_mb <= MB_W'({1'b0, i_cfg.time_step});
            MB_KP:    r_mb <= MB_W'({1'b0, p_gain(i_stage)});
            MB_KD:    r_mb <= MB_W'({1'b0, d_gain(i_stage)});
            MB_CGAIN: r_mb <= MB_W'({1'b0, i_cfg.common_gain});
            MB_DGAIN: r_mb <= MB_W'({1'b0, i_cfg.differential_gain});
            default:  r_mb <= r_mb;
        endcase

        if (i_ctrl.mul_en) begin
            r_prod <= mul_prod;
        end

        // The derivative term is multiplied in two halves: low 16 bits, then
        // the signed upper part, whose product is shifted up by 16.
        unique case (i_ctrl.post)
            POST_DERIV:      r_deriv <= r_prod[DERIV_W+FRAC_W-1:FRAC_W];
            POST_ACC_LOAD:   r_acc <= r_prod;
            POST_ACC_ADD:    r_acc <= r_acc + r_prod;
            POST_ACC_ADD_HI: r_acc <= r_acc + {r_prod[PROD_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
            POST_STAGE_OUT:  r_y[i_stage] <= stage_y;
            POST_CPART:      r_cpart <= r_prod[PART_W+FRAC_W-1:FRAC_W];
            POST_DPART:      r_dpart <= r_prod[PART_W+FRAC_W-1:FRAC_W];
            default:         r_acc <= r_acc;
        endcase
    end

    always_comb begin
        sum_l = SUM_W'({1'b0, i_cfg.thrust_mean}) + SUM_W'(r_cpart) + SUM_W'(r_dpart);
        sum_r = SUM_W'({1'b0, i_cfg.thrust_mean}) + SUM_W'(r_cpart) - SUM_W'(r_dpart);
        if (sum_l > SUM_W'(MAX32)) begin
            o_result.left_thrust = MAX32;
        end else if (sum_l < SUM_W'(MIN32)) begin
            o_result.left_thrust = MIN32;
        end else begin
            o_result.left_thrust = sum_l[DATA_W-1:0];
        end
        if (sum_r > SUM_W'(MAX32)) begin
            o_result.right_thrust = MAX32;
        end else if (sum_r < SUM_W'(MIN32)) begin
            o_result.right_thrust = MIN32;
        end else begin
            o_result.right_thrust = sum_r[DATA_W-1:0];
        end
    end

endmodule

[rtl/cascaded_pid_twin_thruster.sv]
// Cascaded PD controller for a twin-thruster craft. Each input word carries
// horizontal error, vertical error, vertical speed and tilt angle (signed
// Q16.16); four chained stages turn them into a target angle, a differential
// action, a target speed and a common action, and one output word carries
// left and right thrust, saturated to 32 bits. One word is worked on at a
// time by a microcoded sequencer that drives a single shared 34x26
// multiplier: a 13-step stage program runs four times, then six steps scale
// the actions. A new word is taken only once the result of the last one has
// entered the output register, which waits while an earlier result is still
// stalled there. Configuration registers (0 thrust_mean, 1 common_gain,
// 2 differential_gain, 3 time_step, 4 inverse_time_step) may only be written
// while no word is in progress.
module cascaded_pid_twin_thruster (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  cpt_pkg::t_in_word                 i_in_word,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output cpt_pkg::t_out_word                o_out_word,
    input  logic                              i_cfg_we,
    input  logic [cpt_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [cpt_pkg::CFG_W-1:0]         i_cfg_data
);
    import cpt_pkg::*;

    t_cfg               r_cfg;
    t_in_word           r_in_word;
    t_out_word          r_out_word;
    logic               r_out_valid;
    t_out_word          dp_result;
    t_ctrl              seq_ctrl;
    logic [STAGE_W-1:0] seq_stage;
    logic               seq_busy;
    logic               in_fire;
    logic               out_free;
    logic               emit_fire;

    assign o_in_stall = seq_busy;
    assign in_fire    = i_in_valid && !seq_busy;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign emit_fire  = (seq_ctrl.post == POST_EMIT) && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.thrust_mean       <= 17'd2621;
            r_cfg.common_gain       <= 17'd2621;
            r_cfg.differential_gain <= 17'd197;
            r_cfg.time_step         <= 17'd1092;
            r_cfg.inverse_time_step <= 24'd3932160;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_THRUST_MEAN:       r_cfg.thrust_mean       <= i_cfg_data[16:0];
                CFG_COMMON_GAIN:       r_cfg.common_gain       <= i_cfg_data[16:0];
                CFG_DIFFERENTIAL_GAIN: r_cfg.differential_gain <= i_cfg_data[16:0];
                CFG_TIME_STEP:         r_cfg.time_step         <= i_cfg_data[16:0];
                CFG_INVERSE_TIME_STEP: r_cfg.inverse_time_step <= i_cfg_data;
                default:               r_cfg <= r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_word <= i_in_word;
        end
        if (emit_fire) begin
            r_out_word <= dp_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    cpt_useq u_useq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_fire),
        .i_out_free (out_free),
        .o_ctrl     (seq_ctrl),
        .o_stage    (seq_stage),
        .o_busy     (seq_busy)
    );

    cpt_dpath u_dpath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (seq_ctrl),
        .i_stage   (seq_stage),
        .i_in_word (r_in_word),
        .i_cfg     (r_cfg),
        .o_result  (dp_result)
    );

endmodule

[tb/thrust_check_pkg.sv]
package thrust_check_pkg;
    import cpt_pkg::*;

    localparam longint Q32_HI = 64'sh0000_0000_7FFF_FFFF;
    localparam longint Q32_LO = -64'sh0000_0000_8000_0000;
    localparam longint Q48_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint Q48_LO = -64'sh0000_8000_0000_0000;

    class thrust_scoreboard;
        longint mean_q  = 2621;
        longint cgain_q = 2621;
        longint dgain_q = 197;
        longint dt_q    = 1092;
        longint inv_dt_q = 3932160;

        longint last_err[STAGE_COUNT];
        longint integ[STAGE_COUNT];

        t_out_word expected_thrust[$];
        int mismatches;
        int words_checked;

        function longint clamp(longint v, longint lo, longint hi);
            if (v < lo) return lo;
            if (v > hi) return hi;
            return v;
        endfunction

        // One PD stage. The integral is tracked although every integral gain
        // is zero, so it never reaches the thrust.
        function longint pid_stage(logic [STAGE_W-1:0] stg, longint e_raw);
            longint kp, kd, lim, e, d, inc, acc;
            kp = 0;
            kd = 0;
            lim = 0;
            case (stg)
                STG_X: begin
                    kp = 13107;
                    kd = 13107;
                    lim = 25 * 65536;
                end
                STG_A: begin
                    kp = 1311;
                    kd = 655;
                    lim = 65536;
                end
                STG_Y: begin
                    kp = 163840;
                    kd = 98304;
                    lim = 100 * 65536;
                end
                STG_S: begin
                    kp = 65536;
                    kd = 0;
                    lim = 65536;
                end
            endcase
            e = clamp(e_raw, Q32_LO, Q32_HI);
            d = ((e - last_err[stg]) * inv_dt_q) >>> 16;
            inc = (e * dt_q) >>> 16;
            integ[stg] = clamp(integ[stg] + inc, Q48_LO, Q48_HI);
            acc = kp * e + kd * d;
            last_err[stg] = e;
            return clamp(acc >>> 16, -lim, lim);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_THRUST_MEAN:       mean_q   = longint'(data[16:0]);
                CFG_COMMON_GAIN:       cgain_q  = longint'(data[16:0]);
                CFG_DIFFERENTIAL_GAIN: dgain_q  = longint'(data[16:0]);
                CFG_TIME_STEP:         dt_q     = longint'(data[16:0]);
                CFG_INVERSE_TIME_STEP: inv_dt_q = longint'(data[23:0]);
                default: ;
            endcase
        endfunction

        function t_out_word predict_thrust(t_in_word w);
            t_out_word r;
            longint target_angle, diff_act, target_speed, common_act;
            longint c_part, d_part;
            target_angle = pid_stage(STG_X, -longint'(w.horizontal_error));
            diff_act = pid_stage(STG_A, longint'(w.tilt_angle) - target_angle);
            target_speed = pid_stage(STG_Y, longint'(w.vertical_error));
            common_act = pid_stage(STG_S, longint'(w.vertical_speed) - target_speed);
            c_part = (common_act * cgain_q) >>> 16;
            d_part = (diff_act * dgain_q) >>> 16;
            r.left_thrust = 32'(clamp(mean_q + c_part + d_part, Q32_LO, Q32_HI));
            r.right_thrust = 32'(clamp(mean_q + c_part - d_part, Q32_LO, Q32_HI));
            return r;
        endfunction

        function void note_word(t_in_word w);
            expected_thrust.push_back(predict_thrust(w));
        endfunction

        function void check_word(t_out_word got);
            t_out_word want;
            if (expected_thrust.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected thrust word %h with nothing pending", got);
                return;
            end
            want = expected_thrust.pop_front();
            words_checked++;
            if (got.left_thrust !== want.left_thrust ||
                    got.right_thrust !== want.right_thrust) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("word %0d: left exp %h got %h, right exp %h got %h",
                             words_checked, want.left_thrust, got.left_thrust,
                             want.right_thrust, got.right_thrust);
            end
        endfunction

        function int pending();
            return expected_thrust.size();
        endfunction

        function int failures();
            return mismatches + expected_thrust.size();
        endfunction
    endclass

endpackage

[tb/cascaded_pid_twin_thruster_tb.sv]
module cascaded_pid_twin_thruster_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cpt_pkg::*;
    import thrust_check_pkg::*;

    localparam int QUIET_LIMIT      = 4000;
    localparam int HOLD_CYCLES      = 400;
    localparam int IDLE_SETTLE      = 8;
    localparam int END_SETTLE       = 80;
    localparam int RANDOM_PER_PHASE = 150;
    localparam int RANDOM_PHASES    = 7;
    localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_MAX = 32'h8000_0000;

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    t_in_word              i_in_word = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_word             o_out_word;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_W-1:0]      i_cfg_data = '0;

    thrust_scoreboard sb;
    bit               in_quiet;
    bit               out_quiet;
    bit               hold_out_req;
    logic [31:0]      walk_pos[4];
    int               words_sent;
    int               cfg_writes;

    cascaded_pid_twin_thruster dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we)
                sb.write_reg(i_cfg_index, i_cfg_data);
            if (i_in_valid && !o_in_stall)
                sb.note_word(i_in_word);
            if (o_out_valid && !i_out_stall)
                sb.check_word(o_out_word);
        end
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("no word moved for %0d cycles, %0d results still pending",
                 QUIET_LIMIT, sb.pending());
        $display("TB_ERROR");
        $finish;
    end

    function automatic int stall_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 4);
        if (r < 95) return $urandom_range(10, 60);
        return $urandom_range(100, 200);
    endfunction

    // Receiver side. A hold request keeps stall high long enough for the
    // block to fill up and push back on its input.
    initial begin : out_side
        int n;
        @(posedge i_clk);
        forever begin
            if (hold_out_req) begin
                hold_out_req = 1'b0;
                n = HOLD_CYCLES;
                i_out_stall <= 1'b1;
            end else if (out_quiet || $urandom_range(0, 99) < 70) begin
                n = 1;
                i_out_stall <= 1'b0;
            end else begin
                n = stall_len();
                i_out_stall <= 1'b1;
            end
            repeat (n) @(posedge i_clk);
        end
    end

    function automatic int pick_gap();
        int r;
        if (in_quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 20);
        return $urandom_range(40, 120);
    endfunction

    task automatic send_word(input t_in_word w);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        cfg_writes++;
    endtask

    task automatic program_regs(input logic [CFG_W-1:0] mean, input logic [CFG_W-1:0] cgain,
                                input logic [CFG_W-1:0] dgain, input logic [CFG_W-1:0] dt,
                                input logic [CFG_W-1:0] inv_dt);
        write_reg(CFG_THRUST_MEAN, mean);
        write_reg(CFG_COMMON_GAIN, cgain);
        write_reg(CFG_DIFFERENTIAL_GAIN, dgain);
        write_reg(CFG_TIME_STEP, dt);
        write_reg(CFG_INVERSE_TIME_STEP, inv_dt);
    endtask

    // Registers change only with the block idle, so drain every result first.
    task automatic end_phase();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (IDLE_SETTLE) @(posedge i_clk);
    endtask

    function automatic t_in_word mk(input logic [31:0] h, input logic [31:0] v,
                                    input logic [31:0] s, input logic [31:0] a);
        t_in_word w;
        w.horizontal_error = h;
        w.vertical_error = v;
        w.vertical_speed = s;
        w.tilt_angle = a;
        return w;
    endfunction

    // Upper bits of the 17-bit registers are sometimes junk to check masking.
    function automatic logic [CFG_W-1:0] pick_q16();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return 24'd65536;
            2, 3: return 24'($urandom_range(0, 65536));
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_inverse();
        case ($urandom_range(0, 5))
            0: return 24'd1;
            1: return 24'hFF_FFFF;
            2: return '0;
            3: return 24'($urandom_range(1, 8388608));
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] fresh_value();
        logic [31:0] v;
        int r;
        r = $urandom_range(0, 99);
        v = $urandom;
        if (r < 45) return 32'($urandom_range(0, 524288)) - 32'd262144;
        if (r < 65) return {{8{v[23]}}, v[23:0]};
        if (r < 85) return v;
        case ($urandom_range(0, 5))
            0: return POS_MAX;
            1: return NEG_MAX;
            2: return '0;
            3: return 32'd1;
            4: return 32'hFFFF_FFFF;
            default: return 32'h0001_0000;
        endcase
    endfunction

    // Mostly smooth trajectories so the derivative terms stay meaningful,
    // with jumps to fresh values now and then.
    function automatic t_in_word next_random_word();
        for (int i = 0; i < 4; i++) begin
            if ($urandom_range(0, 9) < 7)
                walk_pos[i] = walk_pos[i] + 32'($urandom_range(0, 8192)) - 32'd4096;
            else
                walk_pos[i] = fresh_value();
        end
        return mk(walk_pos[0], walk_pos[1], walk_pos[2], walk_pos[3]);
    endfunction

    initial begin : stimulus
        t_in_word edge_words[$];
        sb = new;
        for (int i = 0; i < 4; i++) walk_pos[i] = '0;
        edge_words = '{
            mk(POS_MAX, NEG_MAX, POS_MAX, NEG_MAX),
            mk(NEG_MAX, POS_MAX, NEG_MAX, POS_MAX),
            mk(32'd65536, 32'd131072, -32'sd32768, 32'd6554),
            mk('0, '0, '0, '0)
        };
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset configuration: field extremes, saturated stage errors, lsb steps.
        send_word(mk('0, '0, '0, '0));
        send_word(mk(POS_MAX, POS_MAX, POS_MAX, POS_MAX));
        send_word(mk(POS_MAX, POS_MAX, POS_MAX, POS_MAX));
        send_word(mk(NEG_MAX, NEG_MAX, NEG_MAX, NEG_MAX));
        send_word(mk(NEG_MAX, NEG_MAX, NEG_MAX, NEG_MAX));
        send_word(mk(POS_MAX, NEG_MAX, POS_MAX, NEG_MAX));
        send_word(mk(NEG_MAX, POS_MAX, NEG_MAX, POS_MAX));
        send_word(mk(32'd65536, 32'd131072, -32'sd32768, 32'd6554));
        send_word(mk(-32'sd65536, -32'sd131072, 32'd32768, -32'sd6554));
        send_word(mk(32'd1, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF));
        send_word(mk(NEG_MAX, '0, '0, '0));
        send_word(mk('0, '0, '0, '0));
        end_phase();

        // Zero period and zero inverse: integral and derivative vanish.
        write_reg(CFG_TIME_STEP, '0);
        write_reg(CFG_INVERSE_TIME_STEP, '0);
        foreach (edge_words[i]) send_word(edge_words[i]);
        end_phase();

        program_regs(24'd65536, 24'd65536, 24'd65536, 24'd65536, 24'hFF_FFFF);
        foreach (edge_words[i]) send_word(edge_words[i]);
        repeat (RANDOM_PER_PHASE) send_word(next_random_word());
        end_phase();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            in_quiet = ($urandom_range(0, 3) == 0);
            out_quiet = ($urandom_range(0, 3) == 0);
            case (ph)
                0: program_regs('0, '0, '0, 24'd1, 24'd1);
                RANDOM_PHASES - 1: program_regs(24'd2621, 24'd2621, 24'd197, 24'd1092,
                                                24'd3932160);
                default: program_regs(pick_q16(), pick_q16(), pick_q16(),
                                      24'd1 | pick_q16(), pick_inverse());
            endcase
            // Indexes past the register list must leave everything unchanged.
            write_reg(CFG_IDX_W'(CFG_INVERSE_TIME_STEP + $urandom_range(1, 3)), 24'($urandom));
            if (ph == 2) begin
                hold_out_req = 1'b1;
                in_quiet = 1'b1;
            end
            repeat (RANDOM_PER_PHASE) send_word(next_random_word());
            end_phase();
        end

        in_quiet = 1'b0;
        out_quiet = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (END_SETTLE) @(posedge i_clk);

        $display("sent %0d words, checked %0d thrust words, %0d mismatches",
                 words_sent, sb.words_checked, sb.mismatches);
        $display("%0d register writes over %0d configurations, including zero period",
                 cfg_writes, RANDOM_PHASES + 3);
        if (sb.failures() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
